/* hw/rtl/gnnr_pkg.sv */
// Shared types and constants of the grouped nearest-neighbor route unit.
// Used by the top level, the distance pipeline and the port checker.
package gnnr_pkg;

  localparam int MAX_POINTS_DEF = 32;
  localparam int COORD_W        = 16;
  localparam int GRP_W          = 4;
  localparam int IDX_W          = 6;
  localparam int SQ_W           = 32;
  localparam int DIST_W         = 33;
  localparam int CFG_ADDR_W     = 3;
  localparam int CFG_DATA_W     = 32;

  // Command codes
  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_RUN   = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  // Register index, taken from paddr[2]
  localparam logic REG_GROUP_COUNT = 1'b0;
  localparam logic REG_START_POINT = 1'b1;

  localparam logic [GRP_W-1:0] GROUP_COUNT_RST = 4'd3;
  localparam logic [IDX_W-1:0] START_POINT_RST = 6'd0;

  typedef struct packed {
    logic [1:0]                cmd;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic [GRP_W-1:0]          point_group;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]  visit_index;
    logic [GRP_W-1:0]  visit_group;
    logic [DIST_W-1:0] distance_sq;
    logic              is_return;
    logic              last;
    logic              overflow;
  } out_item_t;

  // One point store entry
  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [GRP_W-1:0]          grp;
  } entry_t;

  // Candidate handed to the distance pipeline
  typedef struct packed {
    logic                      vld;
    logic                      ret;
    logic [IDX_W-1:0]          idx;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
  } cand_t;

  // Candidate with its squared distance
  typedef struct packed {
    logic                      vld;
    logic                      ret;
    logic [IDX_W-1:0]          idx;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [DIST_W-1:0]         dsq;
  } dist_res_t;

endpackage

/* hw/rtl/grouped_nearest_neighbor_route_unit.sv */
// Grouped nearest-neighbor route unit: point store, route sequencer, APB registers.
// Depends on gnnr_pkg and instantiates gnnr_dist.
//
//  channel | ports                            | handshake
//  --------+----------------------------------+--------------------------------------
//  input   | start, busy, in_data             | taken when start=1 and busy=0
//  result  | out_valid, out_data              | one-cycle strobe, cannot be stalled
//  config  | psel penable pwrite paddr pwdata | written on psel&penable&pwrite, pready=1
//
// A load, clear or ignored command is handled in the idle state and leaves busy low; a load
// result shows in the next cycle. A run holds busy high: one depot read, then one scan of the
// store per stop and one per group (memory read, 3-stage distance pipeline, compare), an emit
// state per stop, and the return leg through the distance pipeline.
// The point store's one read port sets the scan rate: one entry read per cycle.
// Reset is synchronous, active low; the point store is not cleared and needs no pass.
module grouped_nearest_neighbor_route_unit import gnnr_pkg::*; #(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  in_item_t              in_data,
  output logic                  out_valid,
  output out_item_t             out_data,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int IW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_DEP   = 6'b000010,
    ST_SCAN  = 6'b000100,
    ST_EMIT  = 6'b001000,
    ST_RET   = 6'b010000,
    ST_RWAIT = 6'b100000
  } state_t;

  state_t                    state_r, state_nxt;
  logic [CW-1:0]             cnt_r, cnt_nxt;
  logic [GRP_W-1:0]          gcnt_r;
  logic [IDX_W-1:0]          start_r;
  logic [GRP_W-1:0]          grp_r, grp_nxt;
  logic [IW-1:0]             scan_i_r, scan_i_nxt;
  logic                      issue_done_r, issue_done_nxt;
  logic                      v1_r;
  logic [IW-1:0]             idx1_r;
  logic                      found_r, found_nxt;
  logic [DIST_W-1:0]         best_d_r;
  logic [IW-1:0]             best_idx_r;
  logic signed [COORD_W-1:0] best_x_r, best_y_r;
  logic signed [COORD_W-1:0] cur_x_r, cur_y_r, dep_x_r, dep_y_r;
  logic                      out_valid_r, out_valid_nxt;
  out_item_t                 out_r, out_nxt;

  entry_t                    mem [MAX_POINTS];
  entry_t                    rd_r;
  logic [IW-1:0]             rd_addr;
  logic                      mem_we;
  logic [IW-1:0]             mem_waddr;
  entry_t                    mem_wdata;

  logic                      accept, issue, drained, full, take_best, cfg_we;
  logic                      load_cur, load_dep;
  cand_t                     cand;
  dist_res_t                 res;
  logic                      pipe_busy;

  assign accept  = start && !busy;
  assign busy    = (state_r != ST_IDLE);
  assign issue   = (state_r == ST_SCAN) && !issue_done_r;
  assign drained = issue_done_r && !v1_r && !pipe_busy;
  assign full    = (cnt_r >= CW'(MAX_POINTS));
  assign take_best = res.vld && !res.ret &&
                     (!found_r || (res.dsq <= best_d_r));

  // Point store: one write port, one registered read port
  assign rd_addr = (state_r == ST_SCAN) ? scan_i_r : start_r[IW-1:0];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_r <= mem[rd_addr];
  end

  // Feed a matching store entry, or the depot for the return leg
  always_comb begin
    cand.vld = (v1_r && (rd_r.grp == grp_r)) || (state_r == ST_RET);
    cand.ret = (state_r == ST_RET);
    cand.idx = (state_r == ST_RET) ? start_r : IDX_W'(idx1_r);
    cand.x   = (state_r == ST_RET) ? dep_x_r : rd_r.x;
    cand.y   = (state_r == ST_RET) ? dep_y_r : rd_r.y;
  end

  gnnr_dist u_dist (
    .clk   (clk),
    .rst_n (rst_n),
    .cur_x (cur_x_r),
    .cur_y (cur_y_r),
    .cand  (cand),
    .res   (res),
    .busy  (pipe_busy)
  );

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    grp_nxt        = grp_r;
    scan_i_nxt     = scan_i_r;
    issue_done_nxt = issue_done_r;
    found_nxt      = found_r || take_best;
    out_valid_nxt  = 1'b0;
    out_nxt        = '0;
    mem_we         = 1'b0;
    mem_waddr      = cnt_r[IW-1:0];
    mem_wdata      = '0;
    load_cur       = 1'b0;
    load_dep       = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_data.cmd)
            CMD_LOAD: begin
              out_valid_nxt    = 1'b1;
              out_nxt.overflow = full;
              if (!full) begin
                mem_we        = 1'b1;
                mem_wdata.x   = in_data.point_x;
                mem_wdata.y   = in_data.point_y;
                mem_wdata.grp = in_data.point_group;
                cnt_nxt       = cnt_r + CW'(1);
              end
            end
            CMD_RUN: begin
              if (start_r < IDX_W'(cnt_r)) begin
                state_nxt = ST_DEP;
              end
            end
            CMD_CLEAR: begin
              cnt_nxt = '0;
            end
            default: ;
          endcase
        end
      end

      ST_DEP: begin
        load_dep       = 1'b1;
        grp_nxt        = GRP_W'(1);
        scan_i_nxt     = '0;
        issue_done_nxt = 1'b0;
        found_nxt      = 1'b0;
        state_nxt      = (gcnt_r == '0) ? ST_RET : ST_SCAN;
      end

      ST_SCAN: begin
        if (issue) begin
          scan_i_nxt = scan_i_r + IW'(1);
          if (CW'(scan_i_r) == (cnt_r - CW'(1))) begin
            issue_done_nxt = 1'b1;
          end
        end
        if (drained) begin
          if (found_r) begin
            state_nxt = ST_EMIT;
          end else if (grp_r >= gcnt_r) begin
            state_nxt = ST_RET;
          end else begin
            grp_nxt        = grp_r + GRP_W'(1);
            scan_i_nxt     = '0;
            issue_done_nxt = 1'b0;
          end
        end
      end

      ST_EMIT: begin
        out_valid_nxt       = 1'b1;
        out_nxt.visit_index = IDX_W'(best_idx_r);
        out_nxt.visit_group = grp_r;
        out_nxt.distance_sq = best_d_r;
        mem_we              = 1'b1;
        mem_waddr           = best_idx_r;
        mem_wdata.x         = best_x_r;
        mem_wdata.y         = best_y_r;
        load_cur            = 1'b1;
        found_nxt           = 1'b0;
        scan_i_nxt          = '0;
        issue_done_nxt      = 1'b0;
        state_nxt           = ST_SCAN;
      end

      ST_RET: begin
        state_nxt = ST_RWAIT;
      end

      ST_RWAIT: begin
        if (res.vld && res.ret) begin
          out_valid_nxt       = 1'b1;
          out_nxt.visit_index = start_r;
          out_nxt.visit_group = gcnt_r;
          out_nxt.distance_sq = res.dsq;
          out_nxt.is_return   = 1'b1;
          out_nxt.last        = 1'b1;
          mem_we              = 1'b1;
          mem_waddr           = start_r[IW-1:0];
          mem_wdata.x         = dep_x_r;
          mem_wdata.y         = dep_y_r;
          state_nxt           = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cnt_r        <= '0;
      grp_r        <= '0;
      scan_i_r     <= '0;
      issue_done_r <= 1'b0;
      found_r      <= 1'b0;
      v1_r         <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      grp_r        <= grp_nxt;
      scan_i_r     <= scan_i_nxt;
      issue_done_r <= issue_done_nxt;
      found_r      <= found_nxt;
      v1_r         <= issue;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    idx1_r <= scan_i_r;
    out_r  <= out_nxt;
    if (take_best) begin
      best_d_r   <= res.dsq;
      best_idx_r <= res.idx[IW-1:0];
      best_x_r   <= res.x;
      best_y_r   <= res.y;
    end
    if (load_dep) begin
      dep_x_r <= rd_r.x;
      dep_y_r <= rd_r.y;
      cur_x_r <= rd_r.x;
      cur_y_r <= rd_r.y;
    end else if (load_cur) begin
      cur_x_r <= best_x_r;
      cur_y_r <= best_y_r;
    end
  end

  // Configuration registers
  assign cfg_we = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gcnt_r  <= GROUP_COUNT_RST;
      start_r <= START_POINT_RST;
    end else if (cfg_we) begin
      if (paddr[2] == REG_GROUP_COUNT) begin
        gcnt_r <= pwdata[GRP_W-1:0];
      end else begin
        start_r <= pwdata[IDX_W-1:0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_START_POINT) ? CFG_DATA_W'(start_r)
                                                : CFG_DATA_W'(gcnt_r);

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

/* hw/rtl/gnnr_dist.sv */
// Three-stage squared distance pipeline: absolute difference, square, sum.
// Depends on gnnr_pkg for the candidate and result structs.
module gnnr_dist import gnnr_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic signed [COORD_W-1:0] cur_x,
  input  logic signed [COORD_W-1:0] cur_y,
  input  cand_t                     cand,
  output dist_res_t                 res,
  output logic                      busy
);

  logic                      va_r, vb_r, vc_r;
  logic                      reta_r, retb_r;
  logic [IDX_W-1:0]          idxa_r, idxb_r;
  logic signed [COORD_W-1:0] xa_r, ya_r, xb_r, yb_r;
  logic [COORD_W-1:0]        ax_r, ay_r;
  logic [SQ_W-1:0]           sqx_r, sqy_r;
  dist_res_t                 res_r;

  logic signed [COORD_W:0]   dx, dy, ndx, ndy;

  // Coordinate differences and their negations, 17-bit signed
  always_comb begin
    dx  = {cand.x[COORD_W-1], cand.x} - {cur_x[COORD_W-1], cur_x};
    dy  = {cand.y[COORD_W-1], cand.y} - {cur_y[COORD_W-1], cur_y};
    ndx = -dx;
    ndy = -dy;
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
    end else begin
      va_r <= cand.vld;
      vb_r <= va_r;
      vc_r <= vb_r;
    end
  end

  // Stage payloads
  always_ff @(posedge clk) begin
    reta_r <= cand.ret;
    idxa_r <= cand.idx;
    xa_r   <= cand.x;
    ya_r   <= cand.y;
    ax_r   <= dx[COORD_W] ? ndx[COORD_W-1:0] : dx[COORD_W-1:0];
    ay_r   <= dy[COORD_W] ? ndy[COORD_W-1:0] : dy[COORD_W-1:0];

    retb_r <= reta_r;
    idxb_r <= idxa_r;
    xb_r   <= xa_r;
    yb_r   <= ya_r;
    sqx_r  <= ax_r * ax_r;
    sqy_r  <= ay_r * ay_r;

    res_r.vld <= vb_r;
    res_r.ret <= retb_r;
    res_r.idx <= idxb_r;
    res_r.x   <= xb_r;
    res_r.y   <= yb_r;
    res_r.dsq <= {1'b0, sqx_r} + {1'b0, sqy_r};
  end

  always_comb begin
    res     = res_r;
    res.vld = vc_r;
  end

  assign busy = va_r | vb_r | vc_r;

endmodule

/* hw/rtl/gnnr_chk.sv */
// Port-level checker for the route unit, bound to the top level.
// Depends on gnnr_pkg for the item structs and command codes.
module gnnr_chk import gnnr_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input in_item_t  in_data,
  input logic      out_valid,
  input out_item_t out_data
);

  // A load item answers in the next cycle with a plain load result
  a_load_result: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_data.cmd == CMD_LOAD) |=> out_valid && !out_data.is_return)
    else $error("load item without its result");

  // The final stop is the return and frees the block
  a_last_return: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.last |-> out_data.is_return && !busy)
    else $error("last stop is not a return or block still busy");

  // Overflow only marks a load result
  a_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.overflow |-> !out_data.is_return && !out_data.last &&
                                       (out_data.visit_index == '0))
    else $error("overflow on a route stop");

  // Busy only follows an accepted run item
  a_busy_rise: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start) && ($past(in_data.cmd) == CMD_RUN))
    else $error("busy without a run item");

  // Route stops only appear while a run is in progress or as its final return
  a_stop_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.is_return && (out_data.visit_group != '0) |-> busy)
    else $error("route stop outside a run");

endmodule

bind grouped_nearest_neighbor_route_unit gnnr_chk u_gnnr_chk (.*);

/* tb/sv/tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for grouped_nearest_neighbor_route_unit: command and APB drivers,
// a route-predicting scoreboard, a result monitor and a watchdog. Depends on gnnr_pkg.

module tb;
  import gnnr_pkg::*;

  // Command code the block ignores
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam logic [CFG_ADDR_W-1:0] ADDR_GROUP_COUNT = {REG_GROUP_COUNT, 2'b00};
  localparam logic [CFG_ADDR_W-1:0] ADDR_START_POINT = {REG_START_POINT, 2'b00};

  localparam int ITEM_TARGET   = 460;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_CYCLES  = 20;
  localparam int STALL_LIMIT   = 20000;

  // Predicts the stops of every route and checks them in order
  class route_scoreboard;
    logic signed [COORD_W-1:0] pt_x [MAX_POINTS_DEF];
    logic signed [COORD_W-1:0] pt_y [MAX_POINTS_DEF];
    logic [GRP_W-1:0]          pt_g [MAX_POINTS_DEF];
    int unsigned               fill;
    logic [GRP_W-1:0]          n_groups;
    logic [IDX_W-1:0]          depot;
    out_item_t                 stops_due [$];
    int                        errors;
    int                        stops_checked;
    int                        refused_loads;

    function new();
      fill          = 0;
      n_groups      = GROUP_COUNT_RST;
      depot         = START_POINT_RST;
      errors        = 0;
      stops_checked = 0;
      refused_loads = 0;
    endfunction

    function void write_reg(logic sel, logic [CFG_DATA_W-1:0] value);
      if (sel == REG_GROUP_COUNT) begin
        n_groups = value[GRP_W-1:0];
      end else begin
        depot = value[IDX_W-1:0];
      end
    endfunction

    function int pending();
      return stops_due.size();
    endfunction

    function logic [DIST_W-1:0] span_sq(int unsigned a, int unsigned b);
      longint dx;
      longint dy;
      dx = longint'(pt_x[a]) - longint'(pt_x[b]);
      dy = longint'(pt_y[a]) - longint'(pt_y[b]);
      return DIST_W'(dx * dx + dy * dy);
    endfunction

    // Work out the results caused by one accepted item
    function void note_item(in_item_t it);
      out_item_t         r;
      int unsigned       cur;
      int unsigned       best;
      int unsigned       i;
      int                g;
      bit                found;
      logic [DIST_W-1:0] d;
      logic [DIST_W-1:0] best_d;
      r = '0;
      case (it.cmd)
        CMD_LOAD: begin
          if (fill >= MAX_POINTS_DEF) begin
            r.overflow = 1'b1;
            refused_loads++;
          end else begin
            pt_x[fill] = it.point_x;
            pt_y[fill] = it.point_y;
            pt_g[fill] = it.point_group;
            fill++;
          end
          stops_due.push_back(r);
        end
        CMD_CLEAR: begin
          fill = 0;
        end
        CMD_RUN: begin
          // no route unless the depot holds a loaded point
          if (depot < fill) begin
            cur = 32'(depot);
            g   = 1;
            while (g <= n_groups) begin
              found  = 1'b0;
              best   = 0;
              best_d = '0;
              for (i = 0; i < fill; i++) begin
                if (pt_g[i] == g) begin
                  d = span_sq(i, cur);
                  // equal distance: the later index takes over
                  if (!found || d <= best_d) begin
                    found  = 1'b1;
                    best_d = d;
                    best   = i;
                  end
                end
              end
              if (!found) begin
                g++;
              end else begin
                r             = '0;
                r.visit_index = IDX_W'(best);
                r.visit_group = GRP_W'(g);
                r.distance_sq = best_d;
                stops_due.push_back(r);
                pt_g[best] = '0;
                cur        = best;
              end
            end
            // close the tour back at the depot
            r             = '0;
            r.visit_index = depot;
            r.visit_group = n_groups;
            r.distance_sq = span_sq(32'(depot), cur);
            r.is_return   = 1'b1;
            r.last        = 1'b1;
            stops_due.push_back(r);
            pt_g[depot] = '0;
          end
        end
        default: ;
      endcase
    endfunction

    function void flag(string field, logic [DIST_W-1:0] want, logic [DIST_W-1:0] got);
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    endfunction

    // Compare one result with the oldest expected stop
    function void check_result(out_item_t got);
      out_item_t want;
      if (stops_due.size() == 0) begin
        errors++;
        $display("%0t: result with none expected, expected nothing, actual %p", $time, got);
        return;
      end
      want = stops_due.pop_front();
      stops_checked++;
      if (got.visit_index !== want.visit_index) begin
        flag("visit_index", DIST_W'(want.visit_index), DIST_W'(got.visit_index));
      end
      if (got.visit_group !== want.visit_group) begin
        flag("visit_group", DIST_W'(want.visit_group), DIST_W'(got.visit_group));
      end
      if (got.distance_sq !== want.distance_sq) begin
        flag("distance_sq", want.distance_sq, got.distance_sq);
      end
      if (got.is_return !== want.is_return) begin
        flag("is_return", DIST_W'(want.is_return), DIST_W'(got.is_return));
      end
      if (got.last !== want.last) begin
        flag("last", DIST_W'(want.last), DIST_W'(got.last));
      end
      if (got.overflow !== want.overflow) begin
        flag("overflow", DIST_W'(want.overflow), DIST_W'(got.overflow));
      end
    endfunction
  endclass

  logic                  clk     = 1'b0;
  logic                  rst_n   = 1'b0;
  logic                  start   = 1'b0;
  logic                  busy;
  in_item_t              in_data = '0;
  logic                  out_valid;
  out_item_t             out_data;
  logic                  psel    = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr   = '0;
  logic [CFG_DATA_W-1:0] pwdata  = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  route_scoreboard sb;
  int  items_sent = 0;
  int  runs_sent  = 0;
  int  quiet      = 0;
  bit  calm       = 1'b0;

  grouped_nearest_neighbor_route_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Check every strobed result
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      sb.check_result(out_data);
    end
  end

  // End the run when nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || psel) begin
      quiet = 0;
    end else if (quiet >= STALL_LIMIT) begin
      $display("grouped_nearest_neighbor_route_unit test failed");
      $finish;
    end else begin
      quiet = quiet + 1;
    end
  end

  function automatic in_item_t pack(logic [1:0] cmd, int x, int y, int g);
    in_item_t it;
    it.cmd         = cmd;
    it.point_x     = COORD_W'(x);
    it.point_y     = COORD_W'(y);
    it.point_group = GRP_W'(g);
    return it;
  endfunction

  function automatic in_item_t random_load(int spread, int gmax);
    int x;
    int y;
    if (spread == 0) begin
      x = $urandom;
      y = $urandom;
    end else begin
      x = int'($urandom_range(2 * spread)) - spread;
      y = int'($urandom_range(2 * spread)) - spread;
    end
    return pack(CMD_LOAD, x, y, $urandom_range(gmax));
  endfunction

  function automatic in_item_t random_cmd(logic [1:0] cmd);
    return pack(cmd, $urandom, $urandom, $urandom);
  endfunction

  // Hold one item until the block takes it, then maybe idle a few cycles
  task automatic send_item(in_item_t it);
    in_data <= it;
    start   <= 1'b1;
    do @(posedge clk); while (busy);
    sb.note_item(it);
    if (it.cmd != CMD_UNUSED) begin
      items_sent++;
    end
    if (it.cmd == CMD_RUN) begin
      runs_sent++;
    end
    if (!calm && $urandom_range(99) < 7) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // Drain all expected results and let the block go idle
  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Setup cycle, then access cycle until pready
  task automatic cfg_write(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.write_reg(addr[2], data);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    int n;
    int r;
    int spread;
    int gmax;
    int session;
    sb = new();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty store, ignored command, extreme points, ties, revisit
    send_item(random_cmd(CMD_RUN));
    send_item(random_cmd(CMD_UNUSED));
    send_item(pack(CMD_LOAD, 0, 0, 0));
    send_item(pack(CMD_LOAD, 5, 0, 1));
    send_item(pack(CMD_LOAD, 0, -5, 1));
    send_item(pack(CMD_LOAD, 32767, 32767, 2));
    send_item(pack(CMD_LOAD, -32768, -32768, 3));
    send_item(pack(CMD_LOAD, -32768, 32767, 15));
    send_item(pack(CMD_LOAD, 32767, -32768, 3));
    send_item(random_cmd(CMD_RUN));
    send_item(random_cmd(CMD_RUN));
    send_item(pack(CMD_LOAD, 1, 1, 2));

    // Directed: all groups with a depot that sits in a group
    settle();
    cfg_write(ADDR_GROUP_COUNT, 32'd15);
    cfg_write(ADDR_START_POINT, 32'd5);
    send_item(random_cmd(CMD_RUN));

    // Directed: zero groups, then a depot outside the store, then an empty store
    settle();
    cfg_write(ADDR_GROUP_COUNT, 32'd0);
    send_item(random_cmd(CMD_RUN));
    settle();
    cfg_write(ADDR_START_POINT, 32'd63);
    send_item(random_cmd(CMD_RUN));
    send_item(random_cmd(CMD_CLEAR));
    settle();
    cfg_write(ADDR_START_POINT, 32'd0);
    send_item(random_cmd(CMD_RUN));

    // Random: load a point set, then route over it
    session = 0;
    while (items_sent < ITEM_TARGET) begin
      calm = (items_sent >= 200 && items_sent < 300);
      if (session == 0) begin
        n = MAX_POINTS_DEF + 2;
      end else if ($urandom_range(19) == 0) begin
        n = $urandom_range(28, 36);
      end else begin
        n = $urandom_range(1, 10);
      end

      if (session == 0 || $urandom_range(2) == 0) begin
        settle();
        r = $urandom_range(19);
        if (r == 0) begin
          cfg_write(ADDR_GROUP_COUNT, 32'd0);
        end else if (r <= 2) begin
          cfg_write(ADDR_GROUP_COUNT, 32'd15);
        end else if (r == 3) begin
          cfg_write(ADDR_GROUP_COUNT, 32'd1);
        end else begin
          cfg_write(ADDR_GROUP_COUNT, $urandom_range(1, 15));
        end
        r = $urandom_range(9);
        if (r == 0) begin
          cfg_write(ADDR_START_POINT, 32'd63);
        end else if (r == 1) begin
          cfg_write(ADDR_START_POINT, $urandom_range(63));
        end else begin
          cfg_write(ADDR_START_POINT, $urandom_range(n - 1));
        end
      end

      if (session != 0 && $urandom_range(4) != 0) begin
        send_item(random_cmd(CMD_CLEAR));
      end

      r = $urandom_range(2);
      spread = (r == 0) ? 0 : ((r == 1) ? 4 : 300);
      gmax = (sb.n_groups >= 15) ? 15 : sb.n_groups + 1;
      if ($urandom_range(7) == 0) begin
        gmax = 15;
      end
      for (int k = 0; k < n; k++) begin
        if ($urandom_range(29) == 0) begin
          send_item(random_cmd(CMD_UNUSED));
        end
        send_item(random_load(spread, gmax));
      end

      send_item(random_cmd(CMD_RUN));
      if ($urandom_range(3) == 0) begin
        send_item(random_cmd(CMD_RUN));
      end
      session++;
    end

    // Drain and report
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d commands over %0d point sets, %0d of them route runs.",
             items_sent, session, runs_sent);
    $display("Checked %0d results, %0d loads refused on a full store.",
             sb.stops_checked, sb.refused_loads);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("grouped_nearest_neighbor_route_unit test passed");
    end else begin
      $display("grouped_nearest_neighbor_route_unit test failed");
    end
    $finish;
  end

endmodule
